### src/dtxt_pkg.sv
// Package for the DNS TXT response parser: parse phases, parser state and
// result structs, verdict codes and header field positions. No dependencies.
`default_nettype none

package dtxt_pkg;

    typedef enum logic [3:0] {
        PH_HEADER = 4'd0,
        PH_QNAME  = 4'd1,
        PH_QLABEL = 4'd2,
        PH_QPTR   = 4'd3,
        PH_QTAIL  = 4'd4,
        PH_ANAME  = 4'd5,
        PH_ALABEL = 4'd6,
        PH_APTR   = 4'd7,
        PH_AFIXED = 4'd8,
        PH_RDLEN  = 4'd9,
        PH_TXTLEN = 4'd10,
        PH_TXT    = 4'd11,
        PH_DONE   = 4'd12,
        PH_IGNORE = 4'd13
    } t_phase;

    localparam logic [1:0] VERDICT_OK        = 2'd0;
    localparam logic [1:0] VERDICT_BAD_COUNT = 2'd1;
    localparam logic [1:0] VERDICT_TRUNC     = 2'd2;

    localparam logic [3:0] POS_ID_HI      = 4'd0;
    localparam logic [3:0] POS_ID_LO      = 4'd1;
    localparam logic [3:0] POS_QDCOUNT_HI = 4'd4;
    localparam logic [3:0] POS_QDCOUNT_LO = 4'd5;
    localparam logic [3:0] POS_ANCOUNT_HI = 4'd6;
    localparam logic [3:0] POS_ANCOUNT_LO = 4'd7;
    localparam logic [3:0] HEADER_LEN     = 4'd12;
    localparam logic [3:0] QTAIL_LEN      = 4'd4;
    localparam logic [3:0] AFIXED_LEN     = 4'd8;
    localparam logic [3:0] RDLEN_LEN      = 4'd2;

    localparam logic [7:0] PTR_MASK = 8'hC0;

    typedef struct packed {
        t_phase      phase;
        logic [3:0]  field_position;
        logic [7:0]  label_left;
        logic [15:0] data_length;
        logic [15:0] bytes_after_length;
        logic [7:0]  text_left;
        logic [15:0] held_id;
        logic        count_mismatch;
    } t_parse_state;

    localparam t_parse_state PARSE_RESET = '{
        phase:              PH_HEADER,
        field_position:     4'd0,
        label_left:         8'd0,
        data_length:        16'd0,
        bytes_after_length: 16'd0,
        text_left:          8'd0,
        held_id:            16'd0,
        count_mismatch:     1'b0
    };

    typedef struct packed {
        logic        has_result;
        logic [7:0]  text_byte;
        logic        text_valid;
        logic        packet_done;
        logic [1:0]  verdict;
        logic [15:0] message_id;
    } t_result;

endpackage

`default_nettype wire

### src/dtxt_step.sv
// Next-state and result logic of the DNS TXT response parser for one byte.
// Depends on dtxt_pkg for the phase encoding and the state/result structs.
`default_nettype none

module dtxt_step (
    input  wire dtxt_pkg::t_parse_state i_state,
    input  wire logic [7:0]             i_byte,
    input  wire logic                   i_last,
    output dtxt_pkg::t_parse_state      o_state,
    output dtxt_pkg::t_result           o_result
);
    import dtxt_pkg::*;

    t_parse_state n_s;
    logic [7:0]   n_label;
    logic         tv;
    logic [1:0]   verdict;

    always_comb begin
        n_s     = i_state;
        n_label = i_state.label_left - {7'd0, (i_state.label_left != 8'd0)};
        tv      = 1'b0;
        verdict = VERDICT_OK;

        // Bytes after the data length are counted, saturating at all ones.
        if ((i_state.phase == PH_TXTLEN || i_state.phase == PH_TXT ||
             i_state.phase == PH_DONE) && i_state.bytes_after_length != 16'hFFFF) begin
            n_s.bytes_after_length = i_state.bytes_after_length + 16'd1;
        end

        unique case (i_state.phase)
            PH_HEADER: begin
                if (i_state.field_position == POS_ID_HI) begin
                    n_s.held_id[15:8] = i_byte;
                end else if (i_state.field_position == POS_ID_LO) begin
                    n_s.held_id[7:0] = i_byte;
                end else if ((i_state.field_position == POS_QDCOUNT_HI ||
                              i_state.field_position == POS_ANCOUNT_HI) &&
                             i_byte != 8'd0) begin
                    n_s.count_mismatch = 1'b1;
                end else if ((i_state.field_position == POS_QDCOUNT_LO ||
                              i_state.field_position == POS_ANCOUNT_LO) &&
                             i_byte != 8'd1) begin
                    n_s.count_mismatch = 1'b1;
                end
                n_s.field_position = i_state.field_position + 4'd1;
                if (n_s.field_position >= HEADER_LEN) begin
                    n_s.field_position = 4'd0;
                    n_s.phase = n_s.count_mismatch ? PH_IGNORE : PH_QNAME;
                end
            end
            PH_QNAME, PH_ANAME: begin
                if (i_byte == 8'd0) begin
                    n_s.phase = (i_state.phase == PH_QNAME) ? PH_QTAIL : PH_AFIXED;
                    n_s.field_position = 4'd0;
                end else if ((i_byte & PTR_MASK) == PTR_MASK) begin
                    n_s.phase = (i_state.phase == PH_QNAME) ? PH_QPTR : PH_APTR;
                end else begin
                    n_s.label_left = i_byte;
                    n_s.phase = (i_state.phase == PH_QNAME) ? PH_QLABEL : PH_ALABEL;
                end
            end
            PH_QLABEL, PH_ALABEL: begin
                n_s.label_left = n_label;
                if (n_label == 8'd0) begin
                    n_s.phase = (i_state.phase == PH_QLABEL) ? PH_QNAME : PH_ANAME;
                end
            end
            PH_QPTR: begin
                n_s.phase = PH_QTAIL;
                n_s.field_position = 4'd0;
            end
            PH_APTR: begin
                n_s.phase = PH_AFIXED;
                n_s.field_position = 4'd0;
            end
            PH_QTAIL: begin
                n_s.field_position = i_state.field_position + 4'd1;
                if (n_s.field_position >= QTAIL_LEN) begin
                    n_s.field_position = 4'd0;
                    n_s.phase = PH_ANAME;
                end
            end
            PH_AFIXED: begin
                n_s.field_position = i_state.field_position + 4'd1;
                if (n_s.field_position >= AFIXED_LEN) begin
                    n_s.field_position = 4'd0;
                    n_s.phase = PH_RDLEN;
                end
            end
            PH_RDLEN: begin
                n_s.data_length = {i_state.data_length[7:0], i_byte};
                n_s.field_position = i_state.field_position + 4'd1;
                if (n_s.field_position >= RDLEN_LEN) begin
                    n_s.field_position = 4'd0;
                    n_s.bytes_after_length = 16'd0;
                    n_s.phase = PH_TXTLEN;
                end
            end
            PH_TXTLEN: begin
                n_s.text_left = i_byte;
                n_s.phase = (i_byte == 8'd0) ? PH_DONE : PH_TXT;
            end
            PH_TXT: begin
                tv = 1'b1;
                n_s.text_left = i_state.text_left - {7'd0, (i_state.text_left != 8'd0)};
                if (n_s.text_left == 8'd0) begin
                    n_s.phase = PH_DONE;
                end
            end
            default: begin
            end
        endcase

        if (i_last) begin
            if (n_s.phase == PH_HEADER) begin
                verdict = VERDICT_TRUNC;
            end else if (n_s.count_mismatch) begin
                verdict = VERDICT_BAD_COUNT;
            end else if (n_s.phase == PH_DONE &&
                         n_s.bytes_after_length >= n_s.data_length) begin
                verdict = VERDICT_OK;
            end else begin
                verdict = VERDICT_TRUNC;
            end
        end

        o_result.has_result  = tv | i_last;
        o_result.text_byte   = tv ? i_byte : 8'd0;
        o_result.text_valid  = tv;
        o_result.packet_done = i_last;
        o_result.verdict     = verdict;
        o_result.message_id  = n_s.held_id;

        // At packet end everything but the held id returns to reset.
        o_state = n_s;
        if (i_last) begin
            o_state = PARSE_RESET;
            o_state.held_id = n_s.held_id;
        end
    end

endmodule

`default_nettype wire

### src/dns_txt_response_parser_unit.sv
// Top level of the DNS TXT response parser: stream ports, parser state and
// result registers. Depends on dtxt_pkg and dtxt_step.
//
// Usage: packet bytes enter on the slave stream, one byte per request, with
// tlast on the final byte of each DNS response. The block checks the header
// (question and answer counts of one), skips the question and answer names
// and fixed fields, and forwards each TXT string byte as a result request on
// the master stream with tuser set. The request for the final byte carries
// tlast and a verdict: ok, bad counts, or truncated. Other bytes give no
// result. The message id rides along in every result.
//
// A result appears on the master side in the cycle after its byte is
// accepted. One byte is taken per cycle unless the receiver stalls; the
// parser state update between state and result registers is combinational.
// When the receiver stalls with a result pending, o_s_axis_tready drops
// until that result is taken; the pending result holds steady meanwhile.
// Reset (synchronous, active low) returns the parser to the header phase,
// clears the held id and empties the result register.
`default_nettype none

module dns_txt_response_parser_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] in_byte
    input  wire logic        i_s_axis_tlast,   // end_of_packet
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata,   // [7:0] text_byte, [9:8] verdict,
                                               // [25:10] message_id, [31:26] zero
    output logic [0:0]       o_m_axis_tuser,   // [0] text_valid
    output logic             o_m_axis_tlast    // packet_done
);
    import dtxt_pkg::*;

    t_parse_state r_state;
    t_parse_state n_state;
    t_result      n_result;
    logic         in_acc;

    logic         r_out_valid;
    logic [31:0]  r_out_data;
    logic         r_out_user;
    logic         r_out_last;

    dtxt_step u_step (
        .i_state  (r_state),
        .i_byte   (i_s_axis_tdata),
        .i_last   (i_s_axis_tlast),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // A new byte can enter whenever the result slot is empty or is being
    // drained in this cycle.
    assign o_s_axis_tready = ~r_out_valid | i_m_axis_tready;
    assign in_acc          = i_s_axis_tvalid & o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= PARSE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_state <= n_state;
            end
            if (in_acc && n_result.has_result) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload; loaded only when a new result is produced.
    always_ff @(posedge i_clk) begin
        if (in_acc && n_result.has_result) begin
            r_out_data <= {6'd0, n_result.message_id, n_result.verdict, n_result.text_byte};
            r_out_user <= n_result.text_valid;
            r_out_last <= n_result.packet_done;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out_data;
    assign o_m_axis_tuser[0] = r_out_user;
    assign o_m_axis_tlast    = r_out_last;

    // A verdict other than ok appears only on the packet-end result.
    a_verdict_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tlast) |-> (o_m_axis_tdata[9:8] == VERDICT_OK))
        else $error("nonzero verdict on a result that is not packet end");

    // Every result is either a TXT byte or the packet-end report.
    a_result_has_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser[0] || o_m_axis_tlast))
        else $error("result with neither text nor packet end");

    // After the final byte of a packet the parser is back in the header phase.
    a_restart_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_s_axis_tlast) |=> (r_state.phase == PH_HEADER &&
                                        r_state.field_position == 4'd0 &&
                                        !r_state.count_mismatch))
        else $error("parser state not cleared after packet end");

    // An accepted byte that produces a result always shows up on the next cycle.
    a_result_registered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && n_result.has_result) |=> o_m_axis_tvalid)
        else $error("result lost after accepted byte");

endmodule

`default_nettype wire
